// ===== hw/rtl/pwmps_pkg.sv =====
package pwmps_pkg;

    localparam int UNITS  = 4;
    localparam int SLOTS  = UNITS * 2;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam int NS_W    = 32;
    localparam int CLK_W   = 28;
    localparam int COUNT_W = 16;
    localparam int CODE_W  = 3;
    localparam int OPA_W   = 32;
    localparam int OPB_W   = 30;
    localparam int PROD_W  = 60;
    localparam int REM_W   = 30;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    localparam logic [OPB_W-1:0]   NS_PER_S     = 30'd1000000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [COUNT_W-1:0] RESET_PERIOD = 16'd1000;
    localparam logic [CLK_W-1:0]   CLK_RESET    = 28'd48000000;
    localparam logic [CODE_W-1:0]  CODE_MAX     = 3'd7;
    // a period count fits 16 bits while tick * ns < 65536 * 1e9
    localparam logic [PROD_W-1:0]  FIT_LIMIT    = 60'd65536000000000;

    localparam logic [1:0] CH_A = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    typedef enum logic [1:0] {
        CMD_ENABLE  = 2'd0,
        CMD_DISABLE = 2'd1,
        CMD_SET     = 2'd2,
        CMD_GET     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_MUL,
        ST_SRCH_CMP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_SET_PER,
        PH_SET_PUL,
        PH_GET_PER,
        PH_GET_PUL
    } t_phase;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [OPB_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/pwmps_mul.sv =====
module pwmps_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [pwmps_pkg::OPA_W-1:0]   i_a,
    input  logic [pwmps_pkg::OPB_W-1:0]   i_b,
    output logic [pwmps_pkg::PROD_W-1:0]  o_prod
);
    import pwmps_pkg::*;

    logic [OPA_W+OPB_W-1:0] w_full;
    logic [PROD_W-1:0]      r_prod;

    // operands never yield more than 60 significant bits
    assign w_full = {{OPB_W{1'b0}}, i_a} * {{OPA_W{1'b0}}, i_b};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/pwmps_div.sv =====
module pwmps_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pwmps_pkg::t_div_req  i_req,
    output pwmps_pkg::t_div_rsp  o_rsp
);
    import pwmps_pkg::*;

    localparam int STEP_W = $clog2(PROD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [REM_W-1:0]    r_rem;
    logic [PROD_W-1:0]   r_quo;
    logic [OPB_W-1:0]    r_div;

    logic [REM_W:0]      w_rem_sh;
    logic [REM_W:0]      w_diff;
    logic                w_bit;
    logic [REM_W-1:0]    n_rem;
    logic [PROD_W-1:0]   n_quo;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_rem_sh = {r_rem, r_quo[PROD_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_div};
        w_bit    = (w_rem_sh >= {1'b0, r_div});
        n_rem    = w_bit ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
        n_quo    = {r_quo[PROD_W-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hw/rtl/pwm_prescaler_and_duty_setup_top.sv =====
// Channel   Dir  Handshake              Payload
// s         in   i_s_tvalid/o_s_tready  tuser: cmd; tdata: unit, channel, req_period, pulse_ns
// m         out  o_m_tvalid/i_m_tready  tuser: status; tdata: read_period_ns, read_pulse_ns
// cfg       in   i_cfg_wen              core_clock_hz
//
// One command at a time; o_s_tready is low until its result is taken.
// Enable, disable and bad channel go straight to the result. Get: two
// passes of the shared serial divider, none when the tick is zero. Set:
// up to eight multiply/compare rounds for the divider search, then one or two passes.
// Synchronous reset restores counts of 1000, zero high counts, all stopped.
module pwm_prescaler_and_duty_setup_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [1:0] unit, [3:2] channel, [35:4] req_period, [67:36] pulse_ns
    input  logic [pwmps_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // [1:0] cmd
    input  logic [1:0]                           i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [31:0] read_period_ns, [63:32] read_pulse_ns
    output logic [pwmps_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // [0] status
    output logic                                 o_m_tuser,
    input  logic                                 i_cfg_wen,
    input  logic [pwmps_pkg::CLK_W-1:0]          i_cfg_wdata
);
    import pwmps_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase;

    logic [CLK_W-1:0]   r_core_clk;
    logic [COUNT_W-1:0] r_period_cnt [SLOTS];
    logic [COUNT_W-1:0] r_high_cnt   [SLOTS];
    logic [SLOTS-1:0]   r_running;
    logic [CODE_W-1:0]  r_div_code;
    logic [CODE_W-1:0]  r_try;

    logic [SLOT_W-1:0]  r_slot;
    logic [NS_W-1:0]    r_per_ns;
    logic [NS_W-1:0]    r_pul_ns;
    logic [COUNT_W-1:0] r_cyc;
    logic               r_status;
    logic [NS_W-1:0]    r_rd_per;
    logic [NS_W-1:0]    r_rd_pul;

    t_cmd               w_cmd;
    logic [1:0]         w_unit;
    logic [1:0]         w_chan;
    logic [NS_W-1:0]    w_per_in;
    logic [NS_W-1:0]    w_pul_in;
    logic               w_bad;
    logic [SLOT_W-1:0]  w_slot;
    logic               w_accept;
    logic [CLK_W-1:0]   w_tick_cur;
    logic [CLK_W-1:0]   w_tick_try;
    logic               w_fit;
    logic [COUNT_W-1:0] w_hi;

    logic               w_mul_en;
    logic [OPA_W-1:0]   w_mul_a;
    logic [OPB_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    assign w_cmd    = t_cmd'(i_s_tuser);
    assign w_unit   = i_s_tdata[1:0];
    assign w_chan   = i_s_tdata[3:2];
    assign w_per_in = i_s_tdata[35:4];
    assign w_pul_in = i_s_tdata[67:36];
    assign w_bad    = ((w_chan != CH_A) && (w_chan != CH_B)) || (32'(w_unit) >= UNITS);
    assign w_slot   = SLOT_W'({w_unit, (w_chan == CH_B)});
    assign w_accept = i_s_tvalid && o_s_tready;

    assign w_tick_cur = r_core_clk >> r_div_code;
    assign w_tick_try = r_core_clk >> r_try;
    assign w_fit      = (w_prod < FIT_LIMIT);
    assign w_hi       = (w_div_rsp.quotient > {{(PROD_W-COUNT_W){1'b0}}, r_cyc})
                      ? r_cyc : w_div_rsp.quotient[COUNT_W-1:0];

    pwmps_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    pwmps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_bad) begin
                        n_state = ST_OUT;
                    end else begin
                        case (w_cmd)
                            CMD_SET: n_state = (w_per_in == '0) ? ST_MUL : ST_SRCH_MUL;
                            CMD_GET: n_state = (w_tick_cur == '0) ? ST_OUT : ST_MUL;
                            default: n_state = ST_OUT;
                        endcase
                    end
                end
            end
            ST_SRCH_MUL: n_state = ST_SRCH_CMP;
            ST_SRCH_CMP: begin
                if (w_fit) begin
                    n_state = ST_DIV_GO;
                end else if (r_try == CODE_MAX) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_SRCH_MUL;
                end
            end
            ST_MUL:    n_state = ST_DIV_GO;
            ST_DIV_GO: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    case (r_phase)
                        PH_SET_PER: n_state = ST_MUL;
                        PH_GET_PER: n_state = ST_MUL;
                        default:    n_state = ST_OUT;
                    endcase
                end
            end
            ST_OUT: begin
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and shared-unit controls
    always_comb begin
        o_s_tready         = 1'b0;
        o_m_tvalid         = 1'b0;
        w_mul_en           = 1'b0;
        w_mul_a            = '0;
        w_mul_b            = '0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_prod;
        w_div_req.divisor  = ((r_phase == PH_GET_PER) || (r_phase == PH_GET_PUL))
                           ? {{(OPB_W-CLK_W){1'b0}}, w_tick_cur} : NS_PER_S;
        case (r_state)
            ST_IDLE: o_s_tready = 1'b1;
            ST_SRCH_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_per_ns;
                w_mul_b  = {{(OPB_W-CLK_W){1'b0}}, w_tick_try};
            end
            ST_MUL: begin
                w_mul_en = 1'b1;
                case (r_phase)
                    PH_GET_PER: begin
                        w_mul_a = {{(OPA_W-COUNT_W){1'b0}}, r_period_cnt[r_slot]};
                        w_mul_b = NS_PER_S;
                    end
                    PH_GET_PUL: begin
                        w_mul_a = {{(OPA_W-COUNT_W){1'b0}}, r_high_cnt[r_slot]};
                        w_mul_b = NS_PER_S;
                    end
                    default: begin
                        w_mul_a = r_pul_ns;
                        w_mul_b = {{(OPB_W-CLK_W){1'b0}}, w_tick_cur};
                    end
                endcase
            end
            ST_DIV_GO: w_div_req.start = 1'b1;
            ST_OUT:    o_m_tvalid = 1'b1;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_SET_PER;
            r_core_clk <= CLK_RESET;
            r_running  <= '0;
            r_div_code <= '0;
            r_try      <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_period_cnt[i] <= RESET_PERIOD;
                r_high_cnt[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_core_clk <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_slot   <= w_slot;
                        r_per_ns <= w_per_in;
                        r_pul_ns <= w_pul_in;
                        r_status <= w_bad;
                        r_rd_per <= '0;
                        r_rd_pul <= '0;
                        r_try    <= '0;
                        if (!w_bad) begin
                            case (w_cmd)
                                CMD_ENABLE:  r_running[w_slot] <= 1'b1;
                                CMD_DISABLE: r_running[w_slot] <= 1'b0;
                                CMD_SET: begin
                                    // zero period: divide by one, clamp pulse to zero
                                    r_cyc      <= '0;
                                    r_div_code <= (w_per_in == '0) ? '0 : r_div_code;
                                    r_phase    <= PH_SET_PUL;
                                end
                                CMD_GET: r_phase <= PH_GET_PER;
                                default: r_phase <= PH_SET_PER;
                            endcase
                        end
                    end
                end
                ST_SRCH_CMP: begin
                    if (w_fit) begin
                        r_div_code <= r_try;
                        r_phase    <= PH_SET_PER;
                    end else if (r_try == CODE_MAX) begin
                        // nothing fits: saturate at the slowest divider
                        r_cyc      <= COUNT_MAX;
                        r_div_code <= CODE_MAX;
                        r_phase    <= PH_SET_PUL;
                    end else begin
                        r_try <= r_try + 1'b1;
                    end
                end
                ST_DIV_WAIT: begin
                    if (w_div_rsp.done) begin
                        case (r_phase)
                            PH_SET_PER: begin
                                r_cyc   <= w_div_rsp.quotient[COUNT_W-1:0];
                                r_phase <= PH_SET_PUL;
                            end
                            PH_SET_PUL: begin
                                r_period_cnt[r_slot] <= r_cyc;
                                r_high_cnt[r_slot]   <= w_hi;
                            end
                            PH_GET_PER: begin
                                r_rd_per <= w_div_rsp.quotient[NS_W-1:0];
                                r_phase  <= PH_GET_PUL;
                            end
                            default: r_rd_pul <= w_div_rsp.quotient[NS_W-1:0];
                        endcase
                    end
                end
                default: begin
                    r_try <= r_try;
                end
            endcase
        end
    end

    assign o_m_tdata = {r_rd_pul, r_rd_per};
    assign o_m_tuser = r_status;

endmodule
